/* hw/rtl/assert_macros.svh */
// assertion macros shared by the checker files
// no dependencies; include once per file that asserts
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every edge, reset included
`define ABKS_ASSERT(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

// property checked only while out of reset
`define ABKS_ASSERT_RST(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`endif

/* hw/rtl/abks_pkg.sv */
// constants, types, saturation helpers and the microcode rom of the kalman step
// no dependencies; imported by every module of the block
package abks_pkg;

    localparam int AXES        = 3;
    localparam int AXIS_W      = 2;
    localparam int CFG_W       = 21;
    localparam int CFG_IDX_W   = 2;
    localparam int DATA_W      = 32;
    localparam int ACC_W       = 48;
    localparam int FRAC        = 20;
    localparam int NUM_W       = 33;
    localparam int DEN_W       = 34;
    localparam int DIV_STEPS   = 33;
    localparam int DIV_CNT_W   = $clog2(DIV_STEPS);
    localparam int PC_W        = 5;
    localparam int IN_TDATA_W  = 104;
    localparam int OUT_TDATA_W = 72;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_Q_ACCEL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_Q_BIAS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_R_MEAS  = 2'd2;

    localparam logic [CFG_W-1:0] Q_ACCEL_RST = 21'd1049;
    localparam logic [CFG_W-1:0] Q_BIAS_RST  = 21'd10;
    localparam logic [CFG_W-1:0] R_MEAS_RST  = 21'd10486;

    localparam logic signed [DATA_W-1:0] ONE_Q    = 32'sd1048576;
    localparam logic signed [DATA_W-1:0] DATA_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] DATA_MIN = 32'sh8000_0000;
    localparam logic signed [ACC_W-1:0]  SAT_HI   = 48'sh0000_7FFF_FFFF;
    localparam logic signed [ACC_W-1:0]  SAT_LO   = 48'shFFFF_8000_0000;

    // datapath operations
    localparam logic [2:0] DP_NOP   = 3'd0;
    localparam logic [2:0] DP_PRED  = 3'd1;
    localparam logic [2:0] DP_SUM   = 3'd2;
    localparam logic [2:0] DP_DINIT = 3'd3;
    localparam logic [2:0] DP_DSTEP = 3'd4;
    localparam logic [2:0] DP_DEND  = 3'd5;

    // gain / numerator row select
    localparam logic GAIN_A = 1'b0;
    localparam logic GAIN_B = 1'b1;

    // operand sources
    localparam logic [2:0] SRC_A   = 3'd0;
    localparam logic [2:0] SRC_B   = 3'd1;
    localparam logic [2:0] SRC_Y   = 3'd2;
    localparam logic [2:0] SRC_P00 = 3'd3;
    localparam logic [2:0] SRC_P01 = 3'd4;
    localparam logic [2:0] SRC_P10 = 3'd5;
    localparam logic [2:0] SRC_P11 = 3'd6;

    // accumulator operations
    localparam logic [1:0] ACC_NOP  = 2'd0;
    localparam logic [1:0] ACC_ADDB = 2'd1;
    localparam logic [1:0] ACC_SUBB = 2'd2;
    localparam logic [1:0] ACC_SUB  = 2'd3;

    // saturated write-back targets
    localparam logic [2:0] WR_NONE  = 3'd0;
    localparam logic [2:0] WR_ACCEL = 3'd1;
    localparam logic [2:0] WR_BIAS  = 3'd2;
    localparam logic [2:0] WR_AA    = 3'd3;
    localparam logic [2:0] WR_AB    = 3'd4;
    localparam logic [2:0] WR_BA    = 3'd5;
    localparam logic [2:0] WR_BB    = 3'd6;

    // sequencing
    localparam logic [1:0] JMP_NEXT = 2'd0;
    localparam logic [1:0] JMP_LOOP = 2'd1;
    localparam logic [1:0] JMP_END  = 2'd2;

    typedef struct packed {
        logic [2:0]      dp_op;
        logic            sel;
        logic            mul_en;
        logic            mul_k;
        logic [2:0]      mul_b;
        logic [1:0]      acc_op;
        logic [2:0]      acc_base;
        logic [2:0]      wr;
        logic [1:0]      jmp;
        logic [PC_W-1:0] tgt;
    } t_uword;

    typedef struct packed {
        logic init;
        logic step;
    } t_div_ctl;

    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [ACC_W-1:0] x);
        logic signed [DATA_W-1:0] r;
        if (x > SAT_HI) begin
            r = DATA_MAX;
        end else if (x < SAT_LO) begin
            r = DATA_MIN;
        end else begin
            r = x[DATA_W-1:0];
        end
        return r;
    endfunction

    function automatic logic signed [ACC_W-1:0] sx32(input logic signed [DATA_W-1:0] x);
        return {{(ACC_W-DATA_W){x[DATA_W-1]}}, x};
    endfunction

    function automatic logic signed [ACC_W-1:0] zx_cfg(input logic [CFG_W-1:0] x);
        return {{(ACC_W-CFG_W){1'b0}}, x};
    endfunction

    function automatic t_uword mk(
        input logic [2:0]      dp_op,
        input logic            sel,
        input logic            mul_en,
        input logic            mul_k,
        input logic [2:0]      mul_b,
        input logic [1:0]      acc_op,
        input logic [2:0]      acc_base,
        input logic [2:0]      wr,
        input logic [1:0]      jmp,
        input logic [PC_W-1:0] tgt
    );
        t_uword w;
        w.dp_op    = dp_op;
        w.sel      = sel;
        w.mul_en   = mul_en;
        w.mul_k    = mul_k;
        w.mul_b    = mul_b;
        w.acc_op   = acc_op;
        w.acc_base = acc_base;
        w.wr       = wr;
        w.jmp      = jmp;
        w.tgt      = tgt;
        return w;
    endfunction

    // one control word per step; products land one step after they are issued
    function automatic t_uword abks_ucode(input logic [PC_W-1:0] pc);
        t_uword w;
        unique case (pc)
            5'd0:  w = mk(DP_PRED,  GAIN_A, 1'b0, GAIN_A, SRC_A,   ACC_NOP,  SRC_A,
                          WR_NONE,  JMP_NEXT, 5'd0);
            5'd1:  w = mk(DP_SUM,   GAIN_A, 1'b0, GAIN_A, SRC_A,   ACC_NOP,  SRC_A,
                          WR_NONE,  JMP_NEXT, 5'd0);
            5'd2:  w = mk(DP_DINIT, GAIN_A, 1'b0, GAIN_A, SRC_A,   ACC_NOP,  SRC_A,
                          WR_NONE,  JMP_NEXT, 5'd0);
            5'd3:  w = mk(DP_DSTEP, GAIN_A, 1'b0, GAIN_A, SRC_A,   ACC_NOP,  SRC_A,
                          WR_NONE,  JMP_LOOP, 5'd3);
            5'd4:  w = mk(DP_DEND,  GAIN_A, 1'b0, GAIN_A, SRC_A,   ACC_NOP,  SRC_A,
                          WR_NONE,  JMP_NEXT, 5'd0);
            5'd5:  w = mk(DP_DINIT, GAIN_B, 1'b0, GAIN_A, SRC_A,   ACC_NOP,  SRC_A,
                          WR_NONE,  JMP_NEXT, 5'd0);
            5'd6:  w = mk(DP_DSTEP, GAIN_B, 1'b0, GAIN_A, SRC_A,   ACC_NOP,  SRC_A,
                          WR_NONE,  JMP_LOOP, 5'd6);
            5'd7:  w = mk(DP_DEND,  GAIN_B, 1'b0, GAIN_A, SRC_A,   ACC_NOP,  SRC_A,
                          WR_NONE,  JMP_NEXT, 5'd0);
            5'd8:  w = mk(DP_NOP,   GAIN_A, 1'b1, GAIN_A, SRC_Y,   ACC_NOP,  SRC_A,
                          WR_NONE,  JMP_NEXT, 5'd0);
            5'd9:  w = mk(DP_NOP,   GAIN_A, 1'b1, GAIN_B, SRC_Y,   ACC_ADDB, SRC_A,
                          WR_NONE,  JMP_NEXT, 5'd0);
            5'd10: w = mk(DP_NOP,   GAIN_A, 1'b1, GAIN_A, SRC_P00, ACC_ADDB, SRC_B,
                          WR_ACCEL, JMP_NEXT, 5'd0);
            5'd11: w = mk(DP_NOP,   GAIN_A, 1'b1, GAIN_A, SRC_P10, ACC_SUBB, SRC_P00,
                          WR_BIAS,  JMP_NEXT, 5'd0);
            5'd12: w = mk(DP_NOP,   GAIN_A, 1'b1, GAIN_A, SRC_P01, ACC_SUB,  SRC_A,
                          WR_NONE,  JMP_NEXT, 5'd0);
            5'd13: w = mk(DP_NOP,   GAIN_A, 1'b1, GAIN_A, SRC_P11, ACC_SUBB, SRC_P01,
                          WR_AA,    JMP_NEXT, 5'd0);
            5'd14: w = mk(DP_NOP,   GAIN_A, 1'b1, GAIN_B, SRC_P00, ACC_SUB,  SRC_A,
                          WR_NONE,  JMP_NEXT, 5'd0);
            5'd15: w = mk(DP_NOP,   GAIN_A, 1'b1, GAIN_B, SRC_P10, ACC_SUBB, SRC_P10,
                          WR_AB,    JMP_NEXT, 5'd0);
            5'd16: w = mk(DP_NOP,   GAIN_A, 1'b1, GAIN_B, SRC_P01, ACC_SUB,  SRC_A,
                          WR_NONE,  JMP_NEXT, 5'd0);
            5'd17: w = mk(DP_NOP,   GAIN_A, 1'b1, GAIN_B, SRC_P11, ACC_SUBB, SRC_P11,
                          WR_BA,    JMP_NEXT, 5'd0);
            5'd18: w = mk(DP_NOP,   GAIN_A, 1'b0, GAIN_A, SRC_A,   ACC_SUB,  SRC_A,
                          WR_NONE,  JMP_NEXT, 5'd0);
            5'd19: w = mk(DP_NOP,   GAIN_A, 1'b0, GAIN_A, SRC_A,   ACC_NOP,  SRC_A,
                          WR_BB,    JMP_END,  5'd0);
            default: w = '0;
        endcase
        return w;
    endfunction

endpackage

/* hw/rtl/abks_div.sv */
// serial restoring divider: saturated 32-bit quotient of (num * 2^20) / den, truncated
// depends on abks_pkg
module abks_div import abks_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_div_ctl                 i_ctl,
    input  logic signed [NUM_W-1:0]  i_num,
    input  logic [DEN_W-1:0]         i_den,
    output logic                     o_last,
    output logic signed [DATA_W-1:0] o_quot
);

    localparam logic [NUM_W-1:0] Q_POS_LIM = 33'h0_7FFF_FFFF;
    localparam logic [NUM_W-1:0] Q_NEG_LIM = 33'h0_8000_0000;

    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DEN_W:0]       r_rem;
    logic [NUM_W-1:0]     r_nlo;
    logic [NUM_W-1:0]     r_q;
    logic                 r_ovf;
    logic                 r_neg;

    logic [NUM_W-1:0]     w_mag;
    logic [DEN_W:0]       w_top;
    logic [DEN_W:0]       w_trial;
    logic                 w_ge;

    assign w_mag   = i_num[NUM_W-1] ? (~i_num + NUM_W'(1)) : i_num;
    // numerator bits above the quotient window
    assign w_top   = {{(DEN_W+1-(NUM_W-13)){1'b0}}, w_mag[NUM_W-1:13]};
    assign w_trial = {r_rem[DEN_W-1:0], r_nlo[NUM_W-1]};
    assign w_ge    = w_trial >= {1'b0, i_den};
    assign o_last  = r_cnt == DIV_CNT_W'(DIV_STEPS-1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_ctl.init) begin
            r_cnt <= '0;
        end else if (i_ctl.step) begin
            r_cnt <= r_cnt + DIV_CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.init) begin
            r_rem <= w_top;
            r_nlo <= {w_mag[12:0], {FRAC{1'b0}}};
            r_q   <= '0;
            r_ovf <= w_top >= {1'b0, i_den};
            r_neg <= i_num[NUM_W-1];
        end else if (i_ctl.step) begin
            r_rem <= w_ge ? (w_trial - {1'b0, i_den}) : w_trial;
            r_nlo <= {r_nlo[NUM_W-2:0], 1'b0};
            r_q   <= {r_q[NUM_W-2:0], w_ge};
        end
    end

    always_comb begin
        if (r_neg) begin
            if (r_ovf || (r_q > Q_NEG_LIM)) begin
                o_quot = DATA_MIN;
            end else begin
                o_quot = DATA_W'(32'd0 - r_q[DATA_W-1:0]);
            end
        end else begin
            if (r_ovf || (r_q > Q_POS_LIM)) begin
                o_quot = DATA_MAX;
            end else begin
                o_quot = r_q[DATA_W-1:0];
            end
        end
    end

endmodule

/* hw/rtl/accel_bias_kalman_step_top.sv */
// per-axis two-state kalman step (acceleration and bias), microcoded datapath
// depends on abks_pkg and abks_div
//
//  channel   | dir | handshake              | payload
//  ----------+-----+------------------------+------------------------------------------
//  cfg write | in  | i_cfg_wr_en            | i_cfg_idx, i_cfg_wdata (q_accel, q_bias, r_meas)
//  request   | in  | s_axis_tvalid / tready | measurement, prior_accel, prior_bias, axis
//  result    | out | m_axis_tvalid / tready | new_accel, new_bias, out_axis
//
// a request for a valid axis runs the microcode after acceptance; most of the run is spent in
// the two serial divisions through the shared divider, one for each gain
// a request for an axis at or above the axis count is taken without starting the step and gives no result
// a finished result waits in the output register; the next request is taken meanwhile,
// and only the last step holds if the previous result has not yet been taken
// reset returns every axis covariance to identity and the registers to their defaults
module accel_bias_kalman_step_top import abks_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [CFG_W-1:0]       i_cfg_wdata,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // measurement[31:0], prior_accel[63:32], prior_bias[95:64], axis[97:96], zero pad
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // new_accel[31:0], new_bias[63:32], out_axis[65:64], zero pad
    output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    // configuration
    logic [CFG_W-1:0] r_q_accel;
    logic [CFG_W-1:0] r_q_bias;
    logic [CFG_W-1:0] r_r_meas;

    // covariance state, indexed by axis
    logic signed [DATA_W-1:0] r_cov_aa [AXES];
    logic signed [DATA_W-1:0] r_cov_ab [AXES];
    logic signed [DATA_W-1:0] r_cov_ba [AXES];
    logic signed [DATA_W-1:0] r_cov_bb [AXES];

    // sequencer
    logic            r_busy, n_busy;
    logic [PC_W-1:0] r_pc, n_pc;
    logic            r_ovalid, n_ovalid;
    logic            w_load_out;
    t_uword          w_uw;

    // request working registers
    logic signed [DATA_W-1:0] r_z, r_a, r_b, r_y;
    logic [AXIS_W-1:0]        r_axis;
    logic signed [DATA_W-1:0] r_p00, r_p01, r_p10, r_p11;
    logic [DEN_W-1:0]         r_s;
    logic signed [DATA_W-1:0] r_k0, r_k1;
    logic signed [2*DATA_W-1:0] r_prod;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [DATA_W-1:0] r_na, r_nb;
    logic [OUT_TDATA_W-1:0]   r_odata;

    logic                     w_in_acc;
    logic                     w_axis_ok;
    logic [AXIS_W-1:0]        w_in_axis;
    logic signed [ACC_W-1:0]  w_p00, w_p11, w_y, w_s;
    logic signed [NUM_W-1:0]  w_num;
    logic signed [DATA_W-1:0] w_mul_a, w_mul_b, w_base;
    logic signed [ACC_W-1:0]  w_mq;
    logic signed [DATA_W-1:0] w_acc_sat;
    logic                     w_div_last;
    logic signed [DATA_W-1:0] w_quot;
    t_div_ctl                 w_div_ctl;

    assign w_in_axis     = s_axis_tdata[97:96];
    assign w_axis_ok     = 32'(w_in_axis) < AXES;
    assign s_axis_tready = !r_busy;
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;

    assign w_uw = r_busy ? abks_ucode(r_pc) : '0;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q_accel <= Q_ACCEL_RST;
            r_q_bias  <= Q_BIAS_RST;
            r_r_meas  <= R_MEAS_RST;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_idx)
                CFG_Q_ACCEL: r_q_accel <= i_cfg_wdata;
                CFG_Q_BIAS:  r_q_bias  <= i_cfg_wdata;
                CFG_R_MEAS:  r_r_meas  <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // step counter and jumps
    always_comb begin
        n_busy     = r_busy;
        n_pc       = r_pc;
        n_ovalid   = r_ovalid;
        w_load_out = 1'b0;
        if (r_ovalid && m_axis_tready) begin
            n_ovalid = 1'b0;
        end
        if (!r_busy) begin
            if (w_in_acc && w_axis_ok) begin
                n_busy = 1'b1;
                n_pc   = '0;
            end
        end else begin
            unique case (w_uw.jmp)
                JMP_LOOP: n_pc = w_div_last ? (r_pc + PC_W'(1)) : w_uw.tgt;
                JMP_END: begin
                    // hold here while the previous result still waits
                    if (!r_ovalid || m_axis_tready) begin
                        n_busy     = 1'b0;
                        n_ovalid   = 1'b1;
                        w_load_out = 1'b1;
                    end
                end
                default: n_pc = r_pc + PC_W'(1);
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_pc     <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_busy   <= n_busy;
            r_pc     <= n_pc;
            r_ovalid <= n_ovalid;
        end
    end

    // prediction, residual and innovation variance
    assign w_p00 = sx32(r_cov_aa[r_axis]) + zx_cfg(r_q_accel);
    assign w_p11 = sx32(r_cov_bb[r_axis]) + zx_cfg(r_q_bias);
    assign w_y   = sx32(r_z) - sx32(r_a) - sx32(r_b);
    assign w_s   = sx32(r_p00) + sx32(r_p01) + sx32(r_p10) + sx32(r_p11) + zx_cfg(r_r_meas);

    assign w_num = (w_uw.sel == GAIN_B)
                 ? ({r_p10[DATA_W-1], r_p10} + {r_p11[DATA_W-1], r_p11})
                 : ({r_p00[DATA_W-1], r_p00} + {r_p01[DATA_W-1], r_p01});

    assign w_div_ctl.init = w_uw.dp_op == DP_DINIT;
    assign w_div_ctl.step = w_uw.dp_op == DP_DSTEP;

    abks_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_div_ctl),
        .i_num   (w_num),
        .i_den   (r_s),
        .o_last  (w_div_last),
        .o_quot  (w_quot)
    );

    // operand selection
    assign w_mul_a = (w_uw.mul_k == GAIN_B) ? r_k1 : r_k0;

    always_comb begin
        unique case (w_uw.mul_b)
            SRC_P00: w_mul_b = r_p00;
            SRC_P01: w_mul_b = r_p01;
            SRC_P10: w_mul_b = r_p10;
            SRC_P11: w_mul_b = r_p11;
            default: w_mul_b = r_y;
        endcase
    end

    always_comb begin
        unique case (w_uw.acc_base)
            SRC_B:   w_base = r_b;
            SRC_P00: w_base = r_p00;
            SRC_P01: w_base = r_p01;
            SRC_P10: w_base = r_p10;
            SRC_P11: w_base = r_p11;
            default: w_base = r_a;
        endcase
    end

    // product scaled back to q12.20, rounding towards minus infinity
    assign w_mq      = {{(ACC_W-(2*DATA_W-FRAC)){r_prod[2*DATA_W-1]}}, r_prod[2*DATA_W-1:FRAC]};
    assign w_acc_sat = sat32(r_acc);

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_z    <= s_axis_tdata[31:0];
            r_a    <= s_axis_tdata[63:32];
            r_b    <= s_axis_tdata[95:64];
            r_axis <= w_in_axis;
        end
        unique case (w_uw.dp_op)
            DP_PRED: begin
                r_p00 <= sat32(w_p00);
                r_p01 <= r_cov_ab[r_axis];
                r_p10 <= r_cov_ba[r_axis];
                r_p11 <= sat32(w_p11);
                r_y   <= sat32(w_y);
            end
            DP_SUM: begin
                r_s <= (w_s < 48'sd1) ? DEN_W'(1) : w_s[DEN_W-1:0];
            end
            DP_DEND: begin
                if (w_uw.sel == GAIN_B) begin
                    r_k1 <= w_quot;
                end else begin
                    r_k0 <= w_quot;
                end
            end
            default: ;
        endcase
        if (w_uw.mul_en) begin
            r_prod <= w_mul_a * w_mul_b;
        end
        unique case (w_uw.acc_op)
            ACC_ADDB: r_acc <= sx32(w_base) + w_mq;
            ACC_SUBB: r_acc <= sx32(w_base) - w_mq;
            ACC_SUB:  r_acc <= r_acc - w_mq;
            default: ;
        endcase
        if (w_uw.wr == WR_ACCEL) begin
            r_na <= w_acc_sat;
        end
        if (w_uw.wr == WR_BIAS) begin
            r_nb <= w_acc_sat;
        end
        if (w_load_out) begin
            r_odata <= {{(OUT_TDATA_W-2*DATA_W-AXIS_W){1'b0}}, r_axis, r_nb, r_na};
        end
    end

    // covariance write-back
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < AXES; i++) begin
                r_cov_aa[i] <= ONE_Q;
                r_cov_ab[i] <= '0;
                r_cov_ba[i] <= '0;
                r_cov_bb[i] <= ONE_Q;
            end
        end else begin
            unique case (w_uw.wr)
                WR_AA:   r_cov_aa[r_axis] <= w_acc_sat;
                WR_AB:   r_cov_ab[r_axis] <= w_acc_sat;
                WR_BA:   r_cov_ba[r_axis] <= w_acc_sat;
                WR_BB:   r_cov_bb[r_axis] <= w_acc_sat;
                default: ;
            endcase
        end
    end

endmodule

/* hw/rtl/abks_chk.sv */
// port-level checker for the kalman step, bound to the top level
// depends on abks_pkg and assert_macros.svh
`include "assert_macros.svh"

module abks_chk import abks_pkg::*; (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   s_axis_tvalid,
    input logic                   s_axis_tready,
    input logic [IN_TDATA_W-1:0]  s_axis_tdata,
    input logic                   m_axis_tvalid,
    input logic                   m_axis_tready,
    input logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    `ABKS_ASSERT(a_rst_no_result, i_clk, !i_rst_n |=> !m_axis_tvalid, "result valid after reset")

    `ABKS_ASSERT_RST(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")

    `ABKS_ASSERT_RST(a_out_axis, i_clk, i_rst_n, m_axis_tvalid |-> (32'(m_axis_tdata[65:64]) < AXES), "result for an axis out of range")

    `ABKS_ASSERT_RST(a_busy_after_req, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready && (32'(s_axis_tdata[97:96]) < AXES) |=> !s_axis_tready, "request for a valid axis did not start the step")

    `ABKS_ASSERT_RST(a_bad_axis_idle, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready && (32'(s_axis_tdata[97:96]) >= AXES) |=> s_axis_tready, "request for a bad axis started work")

endmodule

bind accel_bias_kalman_step_top abks_chk u_abks_chk (.*);
